[hdl/pidl_pkg.sv]
package pidl_pkg;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD_POS = 2'd2
    } status_t;

    localparam int POS_W    = 5;
    localparam int CNT_W    = 5;
    localparam int WORD_W   = 32;
    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic             ins_en;
        logic             rem_en;
        logic [POS_W-1:0] pos;
    } cell_cmd_t;

endpackage

[hdl/pidl_cell.sv]
module pidl_cell #(
    parameter int INDEX      = 0,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  pidl_pkg::cell_cmd_t   cmd,
    input  logic [DATA_WIDTH-1:0] ins_data,
    input  logic [DATA_WIDTH-1:0] from_left,
    input  logic [DATA_WIDTH-1:0] from_right,
    output logic [DATA_WIDTH-1:0] q
);
    import pidl_pkg::*;

    localparam logic [31:0] IDX = 32'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  idx_gt;
    logic                  idx_eq;

    assign idx_gt = IDX > {{(32-POS_W){1'b0}}, cmd.pos};
    assign idx_eq = IDX == {{(32-POS_W){1'b0}}, cmd.pos};

    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins_en)
        begin
            if (idx_gt)
            begin
                data_next = from_left;
            end
            else if (idx_eq)
            begin
                data_next = ins_data;
            end
        end
        else if (cmd.rem_en && (idx_gt || idx_eq))
        begin
            data_next = from_right;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

[hdl/positional_insert_delete_list.sv]
// Positional insert/delete list built as a row of storage cells.
// Requests enter on the s_ channel: s_tuser carries the action (insert,
// remove, read, clear), s_tdata the position and the word to insert.
// Every request produces exactly one result on the m_ channel with a
// status, the read word, the new length and a full flag.
// On an accepted request all cells update together in the same cycle,
// each taking its own word, its left or right neighbor's word, or the new
// word, so inserts and removes never iterate. The result is registered and
// appears in the cycle after acceptance; one request is taken per cycle
// while the receiver keeps up. s_tready stays high while the result
// register is empty or being taken, so a stalled receiver holds the
// result and blocks new requests only while it stalls. The capacity
// register is written through the cfg_ channel, which is always ready.
// Reset empties the list and sets the capacity to 16; stored words need
// no clearing pass, since only positions below the length are ever read.
module positional_insert_delete_list #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,   // capacity_limit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // position[4:0], data_in[36:5], zero pad[39:37]
    input  logic [1:0]  s_tuser,    // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata     // status[1:0], read_data[33:2], length[38:34], is_full[39]
);
    import pidl_pkg::*;

    localparam int RD_N = (DEPTH < 32) ? DEPTH : 32;

    logic [CNT_W-1:0]      cap_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      eff_cap;
    logic                  out_valid_reg;
    logic [39:0]           out_data_reg;
    logic                  accept;
    action_t               action;
    logic [POS_W-1:0]      pos;
    logic [WORD_W-1:0]     data_in;
    status_t               status;
    logic [WORD_W-1:0]     read_word;
    logic [DATA_WIDTH-1:0] sel_word;
    logic [DATA_WIDTH-1:0] ins_word;
    logic                  full_now;
    cell_cmd_t             cmd;
    logic [DATA_WIDTH-1:0] cell_q [DEPTH];

    assign action  = action_t'(s_tuser);
    assign pos     = s_tdata[POS_W-1:0];
    assign data_in = s_tdata[POS_W+WORD_W-1:POS_W];

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    assign eff_cap  = (32'(cap_reg) > 32'(DEPTH)) ? CNT_W'(DEPTH) : cap_reg;
    assign full_now = count_reg >= eff_cap;

    generate
        if (DATA_WIDTH <= WORD_W)
        begin : g_ins_narrow
            assign ins_word = data_in[DATA_WIDTH-1:0];
        end
        else
        begin : g_ins_wide
            assign ins_word = {{(DATA_WIDTH-WORD_W){1'b0}}, data_in};
        end
    endgenerate

    always_comb
    begin
        status     = ST_OK;
        count_next = count_reg;
        cmd.ins_en = 1'b0;
        cmd.rem_en = 1'b0;
        cmd.pos    = pos;
        unique case (action)
            ACT_INSERT:
            begin
                if (full_now)
                begin
                    status = ST_FULL;
                end
                else if (pos > count_reg)
                begin
                    status = ST_BAD_POS;
                end
                else
                begin
                    cmd.ins_en = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_REMOVE:
            begin
                if (pos >= count_reg)
                begin
                    status = ST_BAD_POS;
                end
                else
                begin
                    cmd.rem_en = accept;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ACT_READ:
            begin
                if (pos >= count_reg)
                begin
                    status = ST_BAD_POS;
                end
            end
            ACT_CLEAR:
            begin
                count_next = '0;
            end
        endcase
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] left_word;
            logic [DATA_WIDTH-1:0] right_word;
            if (i == 0)
            begin : g_first
                assign left_word = ins_word;
            end
            else
            begin : g_mid_l
                assign left_word = cell_q[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_last
                assign right_word = cell_q[i];
            end
            else
            begin : g_mid_r
                assign right_word = cell_q[i+1];
            end
            pidl_cell #(
                .INDEX      (i),
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .ins_data   (ins_word),
                .from_left  (left_word),
                .from_right (right_word),
                .q          (cell_q[i])
            );
        end
    endgenerate

    always_comb
    begin
        sel_word = '0;
        for (int k = 0; k < RD_N; k++)
        begin
            if (32'(pos) == 32'(k))
            begin
                sel_word = cell_q[k];
            end
        end
    end

    generate
        if (DATA_WIDTH >= WORD_W)
        begin : g_rd_wide
            assign read_word = sel_word[WORD_W-1:0];
        end
        else
        begin : g_rd_narrow
            assign read_word = {{(WORD_W-DATA_WIDTH){sel_word[DATA_WIDTH-1]}}, sel_word};
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg[1:0]   <= status;
            out_data_reg[33:2]  <= (action == ACT_READ && status == ST_OK) ? read_word : '0;
            out_data_reg[38:34] <= count_next;
            out_data_reg[39]    <= count_next >= eff_cap;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
